@@ rtl/stt_pkg.sv @@
// Shared types and constants of the source text tokenizer.
package stt_pkg;

  localparam int KindW = 6;

  localparam logic [KindW-1:0] K_END        = 6'd0;
  localparam logic [KindW-1:0] K_IDENT      = 6'd1;
  localparam logic [KindW-1:0] K_IF         = 6'd2;
  localparam logic [KindW-1:0] K_THEN       = 6'd3;
  localparam logic [KindW-1:0] K_ELSE       = 6'd4;
  localparam logic [KindW-1:0] K_WHILE      = 6'd5;
  localparam logic [KindW-1:0] K_INT_KW     = 6'd6;
  localparam logic [KindW-1:0] K_DOUBLE     = 6'd7;
  localparam logic [KindW-1:0] K_BOOL       = 6'd8;
  localparam logic [KindW-1:0] K_TRUEFALSE  = 6'd9;
  localparam logic [KindW-1:0] K_STRING_KW  = 6'd10;
  localparam logic [KindW-1:0] K_VOID       = 6'd11;
  localparam logic [KindW-1:0] K_RETURN     = 6'd12;
  localparam logic [KindW-1:0] K_FN         = 6'd13;
  localparam logic [KindW-1:0] K_BREAK      = 6'd14;
  localparam logic [KindW-1:0] K_CONTINUE   = 6'd15;
  localparam logic [KindW-1:0] K_FOR        = 6'd16;
  localparam logic [KindW-1:0] K_IN         = 6'd17;
  localparam logic [KindW-1:0] K_STEP       = 6'd18;
  localparam logic [KindW-1:0] K_ELSEIF     = 6'd19;
  localparam logic [KindW-1:0] K_STR_BEGIN  = 6'd20;
  localparam logic [KindW-1:0] K_STR_BYTE   = 6'd21;
  localparam logic [KindW-1:0] K_STR_END    = 6'd22;
  localparam logic [KindW-1:0] K_INT        = 6'd23;
  localparam logic [KindW-1:0] K_NUMBER     = 6'd24;
  localparam logic [KindW-1:0] K_RANGE      = 6'd25;
  localparam logic [KindW-1:0] K_EQ         = 6'd26;
  localparam logic [KindW-1:0] K_ASSIGN     = 6'd27;
  localparam logic [KindW-1:0] K_NEQ        = 6'd28;
  localparam logic [KindW-1:0] K_GEQ        = 6'd29;
  localparam logic [KindW-1:0] K_LEQ        = 6'd30;
  localparam logic [KindW-1:0] K_AND        = 6'd31;
  localparam logic [KindW-1:0] K_OR         = 6'd32;
  localparam logic [KindW-1:0] K_INC        = 6'd33;
  localparam logic [KindW-1:0] K_ADD_ASSIGN = 6'd34;
  localparam logic [KindW-1:0] K_DEC        = 6'd35;
  localparam logic [KindW-1:0] K_SUB_ASSIGN = 6'd36;
  localparam logic [KindW-1:0] K_MUL_ASSIGN = 6'd37;
  localparam logic [KindW-1:0] K_MOD_ASSIGN = 6'd38;
  localparam logic [KindW-1:0] K_DIV_ASSIGN = 6'd39;
  localparam logic [KindW-1:0] K_SINGLE     = 6'd40;
  localparam logic [KindW-1:0] K_ERROR      = 6'd41;

  localparam logic [62:0] IntSat = {63{1'b1}};
  // Largest accumulator value that may still take another digit without overflow.
  localparam logic [62:0] IntLim = 63'(64'h7FFF_FFFF_FFFF_FFFF / 64'd10);

  typedef enum logic [9:0] {
    M_IDLE    = 10'b0000000001,
    M_IDENT   = 10'b0000000010,
    M_NUMBER  = 10'b0000000100,
    M_NUMDOT  = 10'b0000001000,
    M_DOT     = 10'b0000010000,
    M_SLASH   = 10'b0000100000,
    M_OP      = 10'b0001000000,
    M_STRING  = 10'b0010000000,
    M_ESC     = 10'b0100000000,
    M_COMMENT = 10'b1000000000
  } mode_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_op_char(input logic [7:0] c);
    return c inside {"=", "!", ">", "<", "&", "|", "+", "-", "*", "%"};
  endfunction

  function automatic logic [KindW-1:0] op_pair(input logic [7:0] p, input logic [7:0] c);
    logic [KindW-1:0] k;
    k = K_END;
    if (c == "=") begin
      case (p)
        "=": k = K_EQ;
        "!": k = K_NEQ;
        ">": k = K_GEQ;
        "<": k = K_LEQ;
        "+": k = K_ADD_ASSIGN;
        "-": k = K_SUB_ASSIGN;
        "*": k = K_MUL_ASSIGN;
        "%": k = K_MOD_ASSIGN;
        default: k = K_END;
      endcase
    end else if (p == c) begin
      case (p)
        "&": k = K_AND;
        "|": k = K_OR;
        "+": k = K_INC;
        "-": k = K_DEC;
        default: k = K_END;
      endcase
    end
    return k;
  endfunction

  // Operation queued from the front part to the back part.
  typedef struct packed {
    logic             is_word;
    logic [KindW-1:0] kind;
    logic [7:0]       code;
    logic             last;
    logic [15:0]      line;
    logic [15:0]      column;
  } op_t;

endpackage

@@ rtl/stt_front.sv @@
// Front part: character classification, position tracking and token decisions.
module stt_front import stt_pkg::*; #(
  parameter int KEYWORD_CHARS = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [7:0]               char_byte,
  input  logic                     end_of_input,
  output op_t [2:0]                ops,
  output logic [1:0]               op_count,
  output logic [KEYWORD_CHARS*8-1:0] word,
  output logic [$clog2(KEYWORD_CHARS+2)-1:0] word_len,
  output logic [62:0]              number
);

  localparam int LenW = $clog2(KEYWORD_CHARS + 2);
  localparam logic [LenW-1:0] KwLen = LenW'(KEYWORD_CHARS);
  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

  mode_t mode, mode_next;
  logic [7:0] kbuf [KEYWORD_CHARS];
  logic [LenW-1:0] ident_length, ident_length_next;
  logic [62:0] number_accum, number_accum_next;
  logic number_has_dot, number_has_dot_next;
  logic [7:0] pending_char, pending_char_next;
  logic [POSITION_BITS-1:0] line_count, line_count_next, column_count, column_count_next;
  logic [POSITION_BITS-1:0] token_line, token_line_next, token_column, token_column_next;
  logic kbuf_we;
  logic [7:0] kbuf_wd;
  logic [LenW-1:0] kbuf_wa;
  op_t [2:0] ops_c;
  logic [1:0] n;

  function automatic logic [62:0] acc_digit(input logic [62:0] a, input logic [7:0] c);
    logic [3:0] d;
    d = c[3:0];
    if (a < IntLim || (a == IntLim && d <= 4'd7)) return 63'(a * 63'd10) + 63'(d);
    return IntSat;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic [POSITION_BITS-1:0] prev;
    logic [15:0] tl, tc;
    logic done, keep;
    logic [KindW-1:0] k;
    c = char_byte;
    prev = column_count;
    done = 1'b0;
    keep = 1'b0;
    k = K_END;
    mode_next = mode;
    ident_length_next = ident_length;
    number_accum_next = number_accum;
    number_has_dot_next = number_has_dot;
    pending_char_next = pending_char;
    line_count_next = line_count;
    column_count_next = column_count;
    token_line_next = token_line;
    token_column_next = token_column;
    kbuf_we = 1'b0;
    kbuf_wd = c;
    kbuf_wa = '0;
    ops_c = '0;
    n = 2'd0;
    tl = 16'(token_line);
    tc = 16'(token_column);
    for (int i = 0; i < 3; i++) begin
      ops_c[i].line = tl;
      ops_c[i].column = tc;
    end
    if (end_of_input) begin
      ops_c[0].kind = K_SINGLE;
      case (mode)
        M_IDENT: begin
          ops_c[0].is_word = 1'b1;
          n = 2'd1;
        end
        M_NUMBER: begin
          ops_c[0].kind = number_has_dot ? K_NUMBER : K_INT;
          n = 2'd1;
        end
        M_NUMDOT: begin
          number_has_dot_next = 1'b1;
          ops_c[0].kind = K_NUMBER;
          n = 2'd1;
        end
        M_DOT: begin
          ops_c[0].code = ".";
          n = 2'd1;
        end
        M_SLASH: begin
          ops_c[0].code = "/";
          n = 2'd1;
        end
        M_OP: begin
          if (pending_char == "=") ops_c[0].kind = K_ASSIGN;
          else ops_c[0].code = pending_char;
          n = 2'd1;
        end
        M_STRING, M_ESC: begin
          ops_c[0].kind = K_ERROR;
          n = 2'd1;
          keep = 1'b1;
        end
        M_COMMENT: keep = 1'b1;
        default: n = 2'd0;
      endcase
      if (!keep) begin
        token_line_next = line_count;
        token_column_next = column_count;
        ops_c[n].line = 16'(line_count);
        ops_c[n].column = 16'(column_count);
      end
      ops_c[n].kind = K_END;
      ops_c[n].code = '0;
      ops_c[n].is_word = 1'b0;
      n = n + 2'd1;
      mode_next = M_IDLE;
    end else begin
      column_count_next = (column_count != PosMax) ? column_count + 1'b1 : PosMax;
      // At most three passes: a token is closed, then the byte is taken up afresh.
      for (int pass = 0; pass < 3; pass++) begin
        if (!done) begin
          case (mode_next)
            M_IDENT: begin
              if (is_alpha(c) || is_digit(c) || c == "_") begin
                if (ident_length_next < KwLen) begin
                  kbuf_we = 1'b1;
                  kbuf_wa = ident_length_next;
                end
                if (ident_length_next <= KwLen) ident_length_next = ident_length_next + 1'b1;
                done = 1'b1;
              end else begin
                ops_c[n].is_word = 1'b1;
                n = n + 2'd1;
                mode_next = M_IDLE;
              end
            end
            M_NUMBER: begin
              if (is_digit(c)) begin
                number_accum_next = acc_digit(number_accum_next, c);
                done = 1'b1;
              end else if (c == ".") begin
                mode_next = M_NUMDOT;
                done = 1'b1;
              end else begin
                ops_c[n].kind = number_has_dot_next ? K_NUMBER : K_INT;
                n = n + 2'd1;
                mode_next = M_IDLE;
              end
            end
            M_NUMDOT: begin
              if (c == ".") begin
                ops_c[n].kind = number_has_dot_next ? K_NUMBER : K_INT;
                ops_c[n+1].kind = K_RANGE;
                ops_c[n+1].line = 16'(line_count);
                ops_c[n+1].column = 16'(prev);
                n = n + 2'd2;
                mode_next = M_IDLE;
                done = 1'b1;
              end else begin
                number_has_dot_next = 1'b1;
                mode_next = M_NUMBER;
              end
            end
            M_DOT: begin
              if (c == ".") begin
                ops_c[n].kind = K_RANGE;
                n = n + 2'd1;
                mode_next = M_IDLE;
                done = 1'b1;
              end else if (is_digit(c)) begin
                mode_next = M_NUMBER;
                number_has_dot_next = 1'b1;
                number_accum_next = 63'(c[3:0]);
                done = 1'b1;
              end else begin
                ops_c[n].kind = K_SINGLE;
                ops_c[n].code = ".";
                n = n + 2'd1;
                mode_next = M_IDLE;
              end
            end
            M_SLASH: begin
              if (c == "/") begin
                mode_next = M_COMMENT;
                done = 1'b1;
              end else if (c == "=") begin
                ops_c[n].kind = K_DIV_ASSIGN;
                n = n + 2'd1;
                mode_next = M_IDLE;
                done = 1'b1;
              end else begin
                ops_c[n].kind = K_SINGLE;
                ops_c[n].code = "/";
                n = n + 2'd1;
                mode_next = M_IDLE;
              end
            end
            M_OP: begin
              k = op_pair(pending_char, c);
              if (k != K_END) begin
                ops_c[n].kind = k;
                done = 1'b1;
              end else if (pending_char == "=") begin
                ops_c[n].kind = K_ASSIGN;
              end else begin
                ops_c[n].kind = K_SINGLE;
                ops_c[n].code = pending_char;
              end
              n = n + 2'd1;
              mode_next = M_IDLE;
            end
            M_STRING: begin
              done = 1'b1;
              if (c == 8'h22) begin
                ops_c[n].kind = K_STR_END;
                n = n + 2'd1;
                mode_next = M_IDLE;
              end else if (c == 8'h5C) begin
                mode_next = M_ESC;
              end else begin
                ops_c[n].kind = K_STR_BYTE;
                ops_c[n].code = c;
                n = n + 2'd1;
              end
            end
            M_ESC: begin
              done = 1'b1;
              mode_next = M_STRING;
              ops_c[n].kind = K_STR_BYTE;
              ops_c[n].code = (c == "n") ? 8'h0A : (c == "t") ? 8'h09 : c;
              n = n + 2'd1;
            end
            M_COMMENT: begin
              if (c == 8'h0A || c == 8'h0D) mode_next = M_IDLE;
              else done = 1'b1;
            end
            default: begin
              done = 1'b1;
              if (is_space(c)) begin
                if (c == 8'h0A) begin
                  line_count_next = (line_count != PosMax) ? line_count + 1'b1 : PosMax;
                  column_count_next = '0;
                end
                mode_next = M_IDLE;
              end else begin
                token_line_next = line_count;
                token_column_next = column_count_next;
                ops_c[n].line = 16'(line_count);
                ops_c[n].column = 16'(column_count_next);
                if (is_alpha(c)) begin
                  mode_next = M_IDENT;
                  kbuf_we = 1'b1;
                  kbuf_wa = '0;
                  ident_length_next = LenW'(1);
                end else if (c == 8'h22) begin
                  mode_next = M_STRING;
                  ops_c[n].kind = K_STR_BEGIN;
                  n = n + 2'd1;
                end else if (c == ".") begin
                  mode_next = M_DOT;
                end else if (is_digit(c)) begin
                  mode_next = M_NUMBER;
                  number_has_dot_next = 1'b0;
                  number_accum_next = 63'(c[3:0]);
                end else if (is_op_char(c)) begin
                  mode_next = M_OP;
                  pending_char_next = c;
                end else if (c == "/") begin
                  mode_next = M_SLASH;
                end else begin
                  mode_next = M_IDLE;
                  ops_c[n].kind = K_SINGLE;
                  ops_c[n].code = c;
                  n = n + 2'd1;
                end
              end
            end
          endcase
        end
      end
    end
    if (n != 2'd0) ops_c[n-2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      ident_length <= '0;
      number_accum <= '0;
      number_has_dot <= 1'b0;
      pending_char <= '0;
      line_count <= POSITION_BITS'(1);
      column_count <= '0;
      token_line <= POSITION_BITS'(1);
      token_column <= '0;
    end else if (take) begin
      mode <= mode_next;
      ident_length <= ident_length_next;
      number_accum <= number_accum_next;
      number_has_dot <= number_has_dot_next;
      pending_char <= pending_char_next;
      line_count <= line_count_next;
      column_count <= column_count_next;
      token_line <= token_line_next;
      token_column <= token_column_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && kbuf_we) kbuf[kbuf_wa[$clog2(KEYWORD_CHARS)-1:0]] <= kbuf_wd;
  end

  // The word and value seen by a queued op are those before this byte is applied.
  always_comb begin
    for (int i = 0; i < KEYWORD_CHARS; i++) word[i*8 +: 8] = kbuf[i];
  end

  assign ops = ops_c;
  assign op_count = n;
  assign word_len = ident_length;
  assign number = number_accum;

endmodule

@@ rtl/stt_back.sv @@
// Back part: keyword matching and result formatting from the operation queue.
module stt_back import stt_pkg::*; #(
  parameter int KEYWORD_CHARS = 8
) (
  input  op_t                      op,
  input  logic [KEYWORD_CHARS*8-1:0] word,
  input  logic [$clog2(KEYWORD_CHARS+2)-1:0] word_len,
  input  logic [62:0]              number,
  output logic [5:0]               token_kind,
  output logic [7:0]               char_code,
  output logic [62:0]              int_value,
  output logic                     bool_value,
  output logic [15:0]              start_line,
  output logic [15:0]              start_column,
  output logic                     last
);

  localparam int LenW = $clog2(KEYWORD_CHARS + 2);

  function automatic logic kw_is(input logic [KEYWORD_CHARS*8-1:0] w,
                                 input logic [LenW-1:0] l, input logic [63:0] s,
                                 input int sl);
    logic m;
    m = (l == LenW'(sl));
    for (int i = 0; i < 8; i++)
      if (i < sl && i < KEYWORD_CHARS && w[i*8 +: 8] != s[(sl-1-i)*8 +: 8]) m = 1'b0;
    return m;
  endfunction

  always_comb begin
    logic [KindW-1:0] kk;
    logic bv;
    kk = K_IDENT;
    bv = 1'b0;
    if      (kw_is(word, word_len, 64'("if"), 2))       kk = K_IF;
    else if (kw_is(word, word_len, 64'("then"), 4))     kk = K_THEN;
    else if (kw_is(word, word_len, 64'("else"), 4))     kk = K_ELSE;
    else if (kw_is(word, word_len, 64'("while"), 5))    kk = K_WHILE;
    else if (kw_is(word, word_len, 64'("int"), 3))      kk = K_INT_KW;
    else if (kw_is(word, word_len, 64'("float"), 5))    kk = K_DOUBLE;
    else if (kw_is(word, word_len, 64'("double"), 6))   kk = K_DOUBLE;
    else if (kw_is(word, word_len, 64'("bool"), 4))     kk = K_BOOL;
    else if (kw_is(word, word_len, 64'("true"), 4)) begin
      kk = K_TRUEFALSE;
      bv = 1'b1;
    end
    else if (kw_is(word, word_len, 64'("false"), 5))    kk = K_TRUEFALSE;
    else if (kw_is(word, word_len, 64'("string"), 6))   kk = K_STRING_KW;
    else if (kw_is(word, word_len, 64'("void"), 4))     kk = K_VOID;
    else if (kw_is(word, word_len, 64'("return"), 6))   kk = K_RETURN;
    else if (kw_is(word, word_len, 64'("fn"), 2))       kk = K_FN;
    else if (kw_is(word, word_len, 64'("break"), 5))    kk = K_BREAK;
    else if (kw_is(word, word_len, 64'("continue"), 8)) kk = K_CONTINUE;
    else if (kw_is(word, word_len, 64'("for"), 3))      kk = K_FOR;
    else if (kw_is(word, word_len, 64'("in"), 2))       kk = K_IN;
    else if (kw_is(word, word_len, 64'("step"), 4))     kk = K_STEP;
    else if (kw_is(word, word_len, 64'("elseif"), 6))   kk = K_ELSEIF;
    token_kind = op.is_word ? kk : op.kind;
    bool_value = op.is_word & bv;
    char_code = op.code;
    int_value = (!op.is_word && op.kind == K_INT) ? number : '0;
    start_line = op.line;
    start_column = op.column;
    last = op.last;
  end

endmodule

@@ rtl/source_text_tokenizer_core.sv @@
// Top level of the source text tokenizer: front part, op queue and back part.
// One source byte or end mark is taken per cycle while the queue has room for the up
// to two results that one byte or end mark can cause; results leave one per cycle, so the
// sustained rate is one byte a cycle when each byte gives at most one token, and the output
// side, one token per pop, sets the pace otherwise. A queued token keeps a copy of the word
// buffer and number value it needs, so the front part runs on independently.
module source_text_tokenizer_core import stt_pkg::*; #(
  parameter int KEYWORD_CHARS = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  token_kind,
  output logic [7:0]  char_code,
  output logic [62:0] int_value,
  output logic        bool_value,
  output logic [15:0] start_line,
  output logic [15:0] start_column,
  output logic        last
);

  localparam int LenW = $clog2(KEYWORD_CHARS + 2);
  localparam int Depth = 4;
  localparam int EntW = $bits(op_t) + KEYWORD_CHARS*8 + LenW + 63;

  op_t [2:0] ops;
  logic [1:0] op_count;
  logic [KEYWORD_CHARS*8-1:0] word;
  logic [LenW-1:0] word_len;
  logic [62:0] number;
  logic take, deq;
  logic [EntW-1:0] q [Depth];
  logic [1:0] rd, wr;
  logic [2:0] cnt;
  logic [EntW-1:0] head;
  op_t head_op;
  logic [KEYWORD_CHARS*8-1:0] head_word;
  logic [LenW-1:0] head_len;
  logic [62:0] head_num;

  stt_front #(.KEYWORD_CHARS(KEYWORD_CHARS), .POSITION_BITS(POSITION_BITS)) u_front (
    .clk, .rst, .take, .char_byte, .end_of_input,
    .ops, .op_count, .word, .word_len, .number
  );

  // Room for the largest burst of two results without counting on the head being taken.
  assign full = (cnt > 3'd1);
  assign take = push && !full;
  assign empty = (cnt == 3'd0);
  assign deq = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0;
      wr <= '0;
      cnt <= '0;
    end else begin
      rd <= rd + 2'(deq);
      wr <= wr + (take ? op_count : 2'd0);
      cnt <= cnt + (take ? 3'(op_count) : 3'd0) - 3'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++)
        if (2'(i) < op_count) q[wr + 2'(i)] <= {ops[i], word, word_len, number};
    end
  end

  assign head = q[rd];
  assign {head_op, head_word, head_len, head_num} = head;

  stt_back #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_back (
    .op(head_op), .word(head_word), .word_len(head_len), .number(head_num),
    .token_kind, .char_code, .int_value, .bool_value, .start_line, .start_column, .last
  );

  assert property (@(posedge clk) disable iff (rst) cnt <= 3'(Depth))
    else $error("op queue overflow");
  assert property (@(posedge clk) disable iff (rst) (take && end_of_input) |-> op_count != 2'd0)
    else $error("end mark gave no result");
  assert property (@(posedge clk) disable iff (rst) !empty && !deq && !take |=> !empty)
    else $error("queued result lost");

endmodule

@@ sim/source_text_tokenizer_core_test.sv @@
// Self-checking testbench for the source text tokenizer core.
`timescale 1ns / 1ps

module source_text_tokenizer_core_test;
  import stt_pkg::*;

  localparam int KeywordChars = 8;
  localparam int CycleLimit = 100_000;
  localparam logic [63:0] ValueMax = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [5:0]  kind;
    logic [7:0]  code;
    logic [62:0] ival;
    logic        bval;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_byte = 8'h00;
  logic        end_of_input = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [5:0]  token_kind;
  logic [7:0]  char_code;
  logic [62:0] int_value;
  logic        bool_value;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        last;

  source_text_tokenizer_core uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .char_byte(char_byte),
    .end_of_input(end_of_input), .empty(empty), .pop(pop), .token_kind(token_kind),
    .char_code(char_code), .int_value(int_value), .bool_value(bool_value),
    .start_line(start_line), .start_column(start_column), .last(last)
  );

  always #2 clk = ~clk;

  // Lexer state as the predictor tracks it.
  mode_t       lx_mode = M_IDLE;
  logic [7:0]  kw_buf[0:KeywordChars-1];
  int          id_len = 0;
  logic [63:0] num_acc = 0;
  logic        has_dot = 1'b0;
  logic [7:0]  held_op = 8'h00;
  logic [15:0] line_cnt = 16'd1;
  logic [15:0] col_cnt = 16'd0;
  logic [15:0] tok_line = 16'd1;
  logic [15:0] tok_col = 16'd0;

  token_t step_tokens[$];
  token_t pending_tokens[$];
  logic [8:0] text_buf[$];

  int send_idle = 0;
  int recv_stall = 0;
  int hold_cycles = 0;
  int failures = 0;
  int cycles = 0;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic op_lead(input logic [7:0] c);
    return c == "=" || c == "!" || c == ">" || c == "<" || c == "&" || c == "|" ||
           c == "+" || c == "-" || c == "*" || c == "%";
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    if (c == "=") begin
      case (p)
        "=": return K_EQ;
        "!": return K_NEQ;
        ">": return K_GEQ;
        "<": return K_LEQ;
        "+": return K_ADD_ASSIGN;
        "-": return K_SUB_ASSIGN;
        "*": return K_MUL_ASSIGN;
        "%": return K_MOD_ASSIGN;
        default: return K_END;
      endcase
    end
    if (p == c) begin
      case (p)
        "&": return K_AND;
        "|": return K_OR;
        "+": return K_INC;
        "-": return K_DEC;
        default: return K_END;
      endcase
    end
    return K_END;
  endfunction

  function automatic void add_token(input logic [5:0] kind, input logic [7:0] code,
                                    input logic [63:0] ival, input logic bval,
                                    input logic [15:0] line, input logic [15:0] col);
    token_t t;
    t.kind = kind;
    t.code = code;
    t.ival = ival[62:0];
    t.bval = bval;
    t.line = line;
    t.col = col;
    t.last = 1'b0;
    if (step_tokens.size() < 3) step_tokens = {step_tokens, t};
  endfunction

  function automatic void add_at_token(input logic [5:0] kind, input logic [7:0] code);
    add_token(kind, code, 64'd0, 1'b0, tok_line, tok_col);
  endfunction

  function automatic void add_word();
    logic [63:0] word;
    logic [5:0]  k;
    logic        b;
    word = 64'd0;
    k = K_IDENT;
    b = 1'b0;
    if (id_len <= KeywordChars) begin
      for (int i = 0; i < id_len; i++) word = {word[55:0], kw_buf[i]};
      case (word)
        "if":       k = K_IF;
        "then":     k = K_THEN;
        "else":     k = K_ELSE;
        "while":    k = K_WHILE;
        "int":      k = K_INT_KW;
        "float":    k = K_DOUBLE;
        "double":   k = K_DOUBLE;
        "bool":     k = K_BOOL;
        "true":     begin k = K_TRUEFALSE; b = 1'b1; end
        "false":    k = K_TRUEFALSE;
        "string":   k = K_STRING_KW;
        "void":     k = K_VOID;
        "return":   k = K_RETURN;
        "fn":       k = K_FN;
        "break":    k = K_BREAK;
        "continue": k = K_CONTINUE;
        "for":      k = K_FOR;
        "in":       k = K_IN;
        "step":     k = K_STEP;
        "elseif":   k = K_ELSEIF;
        default:    k = K_IDENT;
      endcase
    end
    add_token(k, 8'd0, 64'd0, b, tok_line, tok_col);
  endfunction

  function automatic void add_number();
    if (has_dot) add_at_token(K_NUMBER, 8'd0);
    else add_token(K_INT, 8'd0, num_acc, 1'b0, tok_line, tok_col);
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c - 8'h30};
    if (num_acc <= (ValueMax - d) / 64'd10) num_acc = num_acc * 64'd10 + d;
    else num_acc = ValueMax;
  endfunction

  // A byte may close the pending token and then be looked at again from idle.
  function automatic void scan_byte(input logic [7:0] cin, input logic [15:0] prev_col);
    logic [7:0] c;
    logic [5:0] k;
    c = cin;
    for (int pass = 0; pass < 3; pass++) begin
      case (lx_mode)
        M_IDENT: begin
          if (letter(c) || digit(c) || c == "_") begin
            if (id_len < KeywordChars) kw_buf[id_len] = c;
            if (id_len <= KeywordChars) id_len++;
            return;
          end
          add_word();
          lx_mode = M_IDLE;
        end
        M_NUMBER: begin
          if (digit(c)) begin
            take_digit(c);
            return;
          end
          if (c == ".") begin
            lx_mode = M_NUMDOT;
            return;
          end
          add_number();
          lx_mode = M_IDLE;
        end
        M_NUMDOT: begin
          if (c == ".") begin
            add_number();
            add_token(K_RANGE, 8'd0, 64'd0, 1'b0, line_cnt, prev_col);
            lx_mode = M_IDLE;
            return;
          end
          has_dot = 1'b1;
          lx_mode = M_NUMBER;
        end
        M_DOT: begin
          if (c == ".") begin
            add_at_token(K_RANGE, 8'd0);
            lx_mode = M_IDLE;
            return;
          end
          if (digit(c)) begin
            lx_mode = M_NUMBER;
            has_dot = 1'b1;
            num_acc = 64'd0;
            take_digit(c);
            return;
          end
          add_at_token(K_SINGLE, ".");
          lx_mode = M_IDLE;
        end
        M_SLASH: begin
          if (c == "/") begin
            lx_mode = M_COMMENT;
            return;
          end
          if (c == "=") begin
            add_at_token(K_DIV_ASSIGN, 8'd0);
            lx_mode = M_IDLE;
            return;
          end
          add_at_token(K_SINGLE, "/");
          lx_mode = M_IDLE;
        end
        M_OP: begin
          k = pair_kind(held_op, c);
          if (k != K_END) begin
            add_at_token(k, 8'd0);
            lx_mode = M_IDLE;
            return;
          end
          if (held_op == "=") add_at_token(K_ASSIGN, 8'd0);
          else add_at_token(K_SINGLE, held_op);
          lx_mode = M_IDLE;
        end
        M_STRING: begin
          if (c == 8'h22) begin
            add_at_token(K_STR_END, 8'd0);
            lx_mode = M_IDLE;
            return;
          end
          if (c == 8'h5C) begin
            lx_mode = M_ESC;
            return;
          end
          add_at_token(K_STR_BYTE, c);
          return;
        end
        M_ESC: begin
          lx_mode = M_STRING;
          if (c == "n") c = 8'h0A;
          else if (c == "t") c = 8'h09;
          add_at_token(K_STR_BYTE, c);
          return;
        end
        M_COMMENT: begin
          if (c == 8'h0A || c == 8'h0D) lx_mode = M_IDLE;
          else return;
        end
        default: begin
          if (blank(c)) begin
            if (c == 8'h0A) begin
              line_cnt = sat16(line_cnt);
              col_cnt = 16'd0;
            end
            lx_mode = M_IDLE;
            return;
          end
          tok_line = line_cnt;
          tok_col = col_cnt;
          if (letter(c)) begin
            lx_mode = M_IDENT;
            kw_buf[0] = c;
            id_len = 1;
          end else if (c == 8'h22) begin
            lx_mode = M_STRING;
            add_at_token(K_STR_BEGIN, 8'd0);
          end else if (c == ".") begin
            lx_mode = M_DOT;
          end else if (digit(c)) begin
            lx_mode = M_NUMBER;
            has_dot = 1'b0;
            num_acc = 64'd0;
            take_digit(c);
          end else if (op_lead(c)) begin
            lx_mode = M_OP;
            held_op = c;
          end else if (c == "/") begin
            lx_mode = M_SLASH;
          end else begin
            lx_mode = M_IDLE;
            add_at_token(K_SINGLE, c);
          end
          return;
        end
      endcase
    end
  endfunction

  function automatic void close_text();
    logic keep;
    keep = 1'b0;
    case (lx_mode)
      M_IDENT:  add_word();
      M_NUMBER: add_number();
      M_NUMDOT: begin
        has_dot = 1'b1;
        add_number();
      end
      M_DOT:    add_at_token(K_SINGLE, ".");
      M_SLASH:  add_at_token(K_SINGLE, "/");
      M_OP: begin
        if (held_op == "=") add_at_token(K_ASSIGN, 8'd0);
        else add_at_token(K_SINGLE, held_op);
      end
      M_STRING, M_ESC: begin
        add_at_token(K_ERROR, 8'd0);
        keep = 1'b1;
      end
      M_COMMENT: keep = 1'b1;
      default: ;
    endcase
    if (!keep) begin
      tok_line = line_cnt;
      tok_col = col_cnt;
    end
    add_at_token(K_END, 8'd0);
    lx_mode = M_IDLE;
  endfunction

  function automatic void predict_tokens(input logic [7:0] c, input logic e);
    logic [15:0] prev;
    step_tokens.delete();
    if (e) begin
      close_text();
    end else begin
      prev = col_cnt;
      col_cnt = sat16(col_cnt);
      scan_byte(c, prev);
    end
    if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens = {pending_tokens, step_tokens[i]};
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic e);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    char_byte <= c;
    end_of_input <= e;
    do @(posedge clk); while (full);
    predict_tokens(c, e);
    @(negedge clk);
  endtask

  // The input drops push between tests.
  task automatic idle_input();
    push <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_buffer();
    while (text_buf.size() > 0) begin
      logic [8:0] b;
      b = text_buf.pop_front();
      send_byte(b[7:0], b[8]);
    end
    idle_input();
  endtask

  task automatic drain();
    while (pending_tokens.size() > 0) @(negedge clk);
  endtask

  function automatic void put_byte(input logic [8:0] b);
    text_buf = {text_buf, b};
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte({1'b0, s[i]});
  endfunction

  function automatic void add_fragment();
    string words[20] = '{"if", "then", "else", "while", "int", "float", "double", "bool",
                         "true", "false", "string", "void", "return", "fn", "break",
                         "continue", "for", "in", "step", "elseif"};
    string ops[24] = '{"==", "!=", ">=", "<=", "&&", "||", "++", "+=", "--", "-=", "*=",
                       "%=", "/=", "=", "!", ">", "<", "&", "|", "+", "-", "*", "%", "/"};
    string nums[6] = '{"1..2", "3.5", ".25", "..", "4.", "x..y"};
    string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    int n;
    case ($urandom_range(9))
      0: add_str(words[$urandom_range(19)]);
      1: begin
        n = $urandom_range(12, 1);
        add_str(alnum.substr($urandom_range(51), $urandom_range(51)));
        for (int i = 1; i < n; i++) put_byte({1'b0, alnum[$urandom_range(62)]});
      end
      2: begin
        n = $urandom_range(21, 1);
        for (int i = 0; i < n; i++) put_byte({1'b0, 8'("0" + $urandom_range(9))});
      end
      3: add_str(nums[$urandom_range(5)]);
      4: begin
        n = $urandom_range(6);
        put_byte({1'b0, 8'h22});
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(3) == 0) put_byte({1'b0, 8'h5C});
          put_byte({1'b0, 8'($urandom_range(255))});
        end
        put_byte({1'b0, 8'h22});
      end
      5: add_str(ops[$urandom_range(23)]);
      6: begin
        add_str("//");
        n = $urandom_range(5);
        for (int i = 0; i < n; i++) put_byte({1'b0, 8'($urandom_range(126, 32))});
        put_byte({1'b0, ($urandom_range(1) != 0) ? 8'h0A : 8'h0D});
      end
      7: begin
        // Space or one of the control characters from tab to carriage return.
        n = $urandom_range(5);
        put_byte({1'b0, (n == 5) ? 8'h20 : 8'(9 + n)});
      end
      8: put_byte({1'b0, 8'($urandom_range(255))});
      default: put_byte({1'b1, 8'($urandom_range(255))});
    endcase
    if ($urandom_range(1) != 0) put_byte({1'b0, ($urandom_range(3) == 0) ? 8'h0A : 8'h20});
  endfunction

  // Result side: random stalls, plus a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      pop <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin : check_tokens
    token_t want;
    cycles = cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end else if (!rst && pop && !empty) begin
      if (pending_tokens.size() == 0) begin
        $error("token transfer with nothing expected: kind %0d", token_kind);
        failures++;
      end else begin
        want = pending_tokens.pop_front();
        if (token_kind !== want.kind) begin
          $error("token_kind: expected %0d, actual %0d", want.kind, token_kind);
          failures++;
        end
        if (char_code !== want.code) begin
          $error("char_code: expected %0d, actual %0d", want.code, char_code);
          failures++;
        end
        if (int_value !== want.ival) begin
          $error("int_value: expected %0d, actual %0d", want.ival, int_value);
          failures++;
        end
        if (bool_value !== want.bval) begin
          $error("bool_value: expected %0d, actual %0d", want.bval, bool_value);
          failures++;
        end
        if (start_line !== want.line) begin
          $error("start_line: expected %0d, actual %0d", want.line, start_line);
          failures++;
        end
        if (start_column !== want.col) begin
          $error("start_column: expected %0d, actual %0d", want.col, start_column);
          failures++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last);
          failures++;
        end
      end
    end
  end

  task automatic test_keywords();
    send_text("true false continue elseif");
    send_end();
    idle_input();
  endtask

  task automatic test_operators();
    send_text("==!=>=<=&&||++--+=-=*=%=/= /x=y!;.");
    send_end();
    idle_input();
  endtask

  task automatic test_numbers_and_names();
    send_text("99999999999999999999 1..2 .5 7.x abcdefghi");
    send_end();
    idle_input();
  endtask

  task automatic test_strings_and_comments();
    send_text("\"a\\n\\\"\" //c\nz \"o");
    send_end();
    send_end();
    send_text("//");
    send_end();
    idle_input();
  endtask

  // The result side holds off while single characters keep arriving, so the block fills.
  task automatic test_backpressure();
    hold_cycles = 40;
    for (int i = 0; i < 16; i++) send_byte(";", 1'b0);
    idle_input();
  endtask

  task automatic test_random(input int idle, input int stall, input int count);
    send_idle = idle;
    recv_stall = stall;
    while (text_buf.size() < count) add_fragment();
    put_byte({1'b1, 8'h00});
    send_buffer();
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_keywords();
    test_operators();
    test_numbers_and_names();
    test_strings_and_comments();
    drain();
    test_backpressure();
    drain();
    test_random(0, 0, 8);
    test_random(70, 0, 8);
    test_random(0, 70, 8);
    test_random(33, 33, 8);
    drain();
    repeat (30) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ source_text_tokenizer_core.f @@
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_back.sv
rtl/source_text_tokenizer_core.sv
sim/source_text_tokenizer_core_test.sv
